// File: hdl/lnaddr_pkg.sv
// Package for the lattice neighbor address unit: widths, register indexes
// and the pipeline payload types. No dependencies.
package lnaddr_pkg;

	// Lattice limits and field widths
	localparam int MAX_SIDE    = 256;
	localparam int SIDE_W      = 9;
	localparam int COORD_W     = $clog2(MAX_SIDE);
	localparam int IDX_W       = 24;
	localparam int UNIT_W      = 4;
	localparam int DOWN_BIT    = 3;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 24;
	localparam int CFG_IDX_W   = 1;

	// Divider layout: three passes of restoring division, DIV_BITS quotient bits per stage
	localparam int DIV_BITS    = 4;
	localparam int DIV_PER_PASS = IDX_W / DIV_BITS;
	localparam int DIV_PASSES  = 3;
	localparam int DIV_STAGES  = DIV_PASSES * DIV_PER_PASS;

	// Product widths of the recombination
	localparam int PROD1_W     = COORD_W + SIDE_W;
	localparam int PROD2_W     = PROD1_W + SIDE_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LATTICE_SIDE = 1'b0,
		CFG_WRAP_MODE    = 1'b1
	} cfg_reg_t;

	// Partial remainder and shifting dividend / quotient word
	typedef struct packed {
		logic [IDX_W-1:0]   work;
		logic [COORD_W-1:0] rem;
	} div_acc_t;

	// Payload of one divider stage
	typedef struct packed {
		logic [UNIT_W-1:0]  code;
		div_acc_t           acc;
		logic [COORD_W-1:0] t;
		logic [COORD_W-1:0] u;
		logic [IDX_W-1:0]   v;
	} div_stage_t;

	// Stepped coordinates
	typedef struct packed {
		logic [COORD_W-1:0] n0;
		logic [COORD_W-1:0] n1;
		logic [COORD_W-1:0] n2;
		logic               oob;
	} coord_t;

	// First partial recombination
	typedef struct packed {
		logic [PROD1_W-1:0] m1;
		logic [COORD_W-1:0] n0;
		logic               oob;
	} prod_t;

endpackage

// File: hdl/lattice_neighbor_address.sv
// Lattice neighbor address unit: splits a linear site index into three
// coordinates, steps them along a unit vector and recombines them.
// Depends on lnaddr_pkg.
//
// Pipeline: 21 register stages (18 divider stages, coordinate step, two
// multiply stages). Throughput: one request per cycle while the output is
// not stalled. The depth is set by the three chained 24-bit divisions by
// the side, four quotient bits per stage. A stalled output freezes the
// whole pipeline. Reset empties the pipeline, sets the side to 32 and
// selects periodic wraparound.
module lattice_neighbor_address (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [lnaddr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lnaddr_pkg::SIDE_W-1:0]     cfg_data,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lnaddr_pkg::S_TDATA_W-1:0]  s_tdata,  // [23:0] site_index, [27:24] unit_code
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lnaddr_pkg::M_TDATA_W-1:0]  m_tdata,  // [23:0] neighbor_index
	output logic                              m_tuser   // [0] out_of_bounds
);

	localparam int CW = lnaddr_pkg::COORD_W;
	localparam int SW = lnaddr_pkg::SIDE_W;
	localparam int IW = lnaddr_pkg::IDX_W;

	// One chunk of restoring division: DIV_BITS quotient bits
	function automatic lnaddr_pkg::div_acc_t div_chunk(lnaddr_pkg::div_acc_t a,
			logic [SW-1:0] side);
		lnaddr_pkg::div_acc_t r;
		logic [SW-1:0]        trial;
		r = a;
		for (int i = 0; i < lnaddr_pkg::DIV_BITS; i++) begin
			trial  = {r.rem, r.work[IW-1]};
			r.work = {r.work[IW-2:0], 1'b0};
			if (trial >= side) begin
				trial     = trial - side;
				r.work[0] = 1'b1;
			end
			r.rem = trial[CW-1:0];
		end
		return r;
	endfunction

	// Periodic step of a coordinate already below the side
	function automatic logic [CW-1:0] wrap_step(logic [CW-1:0] c, logic mv, logic down,
			logic [SW-1:0] side_m1);
		logic [CW-1:0] r;
		r = c;
		if (mv) begin
			if (down)
				r = (c == '0) ? side_m1[CW-1:0] : c - CW'(1);
			else
				r = ({1'b0, c} == side_m1) ? '0 : c + CW'(1);
		end
		return r;
	endfunction

	// Configuration registers
	logic [SW-1:0] side_q;
	logic          wrap_mode_q;
	logic [SW-1:0] side_m1;

	// Pipeline registers
	lnaddr_pkg::div_stage_t div_s [lnaddr_pkg::DIV_STAGES];  // stages 1 to 18
	logic [lnaddr_pkg::DIV_STAGES-1:0] div_v_s;
	lnaddr_pkg::div_stage_t div_nxt [lnaddr_pkg::DIV_STAGES];
	lnaddr_pkg::coord_t     coord_s19, coord_nxt;
	logic                   coord_v_s19;
	lnaddr_pkg::prod_t      prod_s20;
	logic                   prod_v_s20;
	logic [lnaddr_pkg::PROD2_W-1:0] full_nxt;
	logic [IW-1:0]          nbr_s21;
	logic                   oob_s21;
	logic                   out_v_s21;
	logic                   adv;

	// Write configuration, clamping the side to 1..MAX_SIDE
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q      <= SW'(32);
			wrap_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (lnaddr_pkg::cfg_reg_t'(cfg_index))
				lnaddr_pkg::CFG_LATTICE_SIDE: begin
					if (cfg_data == '0)
						side_q <= SW'(1);
					else if (cfg_data > SW'(lnaddr_pkg::MAX_SIDE))
						side_q <= SW'(lnaddr_pkg::MAX_SIDE);
					else
						side_q <= cfg_data;
				end
				lnaddr_pkg::CFG_WRAP_MODE: begin
					wrap_mode_q <= cfg_data[0];
				end
				default: begin
					side_q <= side_q;
				end
			endcase
		end
	end

	assign side_m1 = side_q - SW'(1);

	// Advance the whole pipeline while the result register is free or taken
	assign adv      = !out_v_s21 || m_tready;
	assign s_tready = adv;

	// Divider stages: pass 1 gives t and idx/L, pass 2 gives u and v,
	// pass 3 reduces v modulo the side
	always_comb begin
		lnaddr_pkg::div_stage_t stg_in;
		stg_in.code     = s_tdata[IW +: lnaddr_pkg::UNIT_W];
		stg_in.acc.work = s_tdata[IW-1:0];
		stg_in.acc.rem  = '0;
		stg_in.t        = '0;
		stg_in.u        = '0;
		stg_in.v        = '0;
		div_nxt[0]      = stg_in;
		div_nxt[0].acc  = div_chunk(stg_in.acc, side_q);
		for (int k = 1; k < lnaddr_pkg::DIV_STAGES; k++) begin
			stg_in = div_s[k-1];
			if (k == lnaddr_pkg::DIV_PER_PASS || k == 2 * lnaddr_pkg::DIV_PER_PASS)
				stg_in.acc.rem = '0;
			if (k == lnaddr_pkg::DIV_PER_PASS)
				stg_in.t = div_s[k-1].acc.rem;
			if (k == 2 * lnaddr_pkg::DIV_PER_PASS) begin
				stg_in.u = div_s[k-1].acc.rem;
				stg_in.v = div_s[k-1].acc.work;
			end
			div_nxt[k]     = stg_in;
			div_nxt[k].acc = div_chunk(stg_in.acc, side_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			div_s <= div_nxt;
	end

	// Step the coordinates and detect a step off a face
	always_comb begin
		lnaddr_pkg::div_stage_t d;
		logic                   down;
		logic [2:0]             mv;
		logic                   oob_t, oob_u, oob_v;
		logic [IW:0]            nv;
		d    = div_s[lnaddr_pkg::DIV_STAGES-1];
		down = d.code[lnaddr_pkg::DOWN_BIT];
		mv   = d.code[2:0] ^ {3{down}};

		oob_t = mv[0] && (down ? (d.t == '0) : ({1'b0, d.t} == side_m1));
		oob_u = mv[1] && (down ? (d.u == '0) : ({1'b0, d.u} == side_m1));
		nv    = {1'b0, d.v};
		if (mv[2])
			nv = down ? nv - (IW+1)'(1) : nv + (IW+1)'(1);
		oob_v = nv >= (IW+1)'(side_q);

		if (wrap_mode_q) begin
			coord_nxt.n0  = down ? d.t - CW'(mv[0]) : d.t + CW'(mv[0]);
			coord_nxt.n1  = down ? d.u - CW'(mv[1]) : d.u + CW'(mv[1]);
			coord_nxt.n2  = nv[CW-1:0];
			coord_nxt.oob = oob_t || oob_u || oob_v;
		end else begin
			coord_nxt.n0  = wrap_step(d.t, mv[0], down, side_m1);
			coord_nxt.n1  = wrap_step(d.u, mv[1], down, side_m1);
			coord_nxt.n2  = wrap_step(d.acc.rem, mv[2], down, side_m1);
			coord_nxt.oob = 1'b0;
		end
	end

	// Second multiply of the recombination
	assign full_nxt = lnaddr_pkg::PROD2_W'(prod_s20.m1) * lnaddr_pkg::PROD2_W'(side_q) +
	                  lnaddr_pkg::PROD2_W'(prod_s20.n0);

	// Hold the stepped coordinates, then recombine in two multiply stages
	always_ff @(posedge clk) begin
		if (adv) begin
			coord_s19 <= coord_nxt;

			prod_s20.m1  <= lnaddr_pkg::PROD1_W'(coord_s19.n2) *
			                lnaddr_pkg::PROD1_W'(side_q) +
			                lnaddr_pkg::PROD1_W'(coord_s19.n1);
			prod_s20.n0  <= coord_s19.n0;
			prod_s20.oob <= coord_s19.oob;

			nbr_s21 <= prod_s20.oob ? '0 : full_nxt[IW-1:0];
			oob_s21 <= prod_s20.oob;
		end
	end

	// Advance the valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s     <= '0;
			coord_v_s19 <= 1'b0;
			prod_v_s20  <= 1'b0;
			out_v_s21   <= 1'b0;
		end else if (adv) begin
			div_v_s     <= {div_v_s[lnaddr_pkg::DIV_STAGES-2:0], s_tvalid};
			coord_v_s19 <= div_v_s[lnaddr_pkg::DIV_STAGES-1];
			prod_v_s20  <= coord_v_s19;
			out_v_s21   <= prod_v_s20;
		end
	end

	assign m_tvalid = out_v_s21;
	assign m_tdata  = nbr_s21;
	assign m_tuser  = oob_s21;

endmodule

// File: sim/tb.sv
// Testbench for lattice_neighbor_address: streams site lookups under several
// side and wrap settings and checks every neighbor against a built-in predictor.
// Depends on lnaddr_pkg and the lattice_neighbor_address RTL.
module tb;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES = 250;

	typedef enum logic [1:0] {
		STEP_NONE,
		STEP_INC,
		STEP_DEC
	} axis_step_t;

	typedef struct packed {
		logic [lnaddr_pkg::IDX_W-1:0] addr;
		logic                         oob;
	} neighbor_t;

	// Predicts neighbor addresses and holds them until the block returns them
	class neighbor_checker;
		logic [lnaddr_pkg::SIDE_W-1:0] side_reg;
		bit                bounded;
		neighbor_t         expected_neighbors[$];
		int                error_count;

		function new();
			side_reg = 9'd32;
			bounded = 1'b0;
			error_count = 0;
		endfunction

		function void set_config(logic [lnaddr_pkg::SIDE_W-1:0] side, bit mode);
			side_reg = side;
			bounded = mode;
		endfunction

		// Clamp the side register to the range the lattice supports
		function int unsigned side_eff();
			int unsigned s;
			s = side_reg;
			if (s == 0) s = 1;
			if (s > lnaddr_pkg::MAX_SIDE) s = lnaddr_pkg::MAX_SIDE;
			return s;
		endfunction

		function neighbor_t neighbor_of(logic [lnaddr_pkg::IDX_W-1:0] site,
				logic [lnaddr_pkg::UNIT_W-1:0] code);
			longint unsigned side, coord[3], moved[3], sum;
			axis_step_t      dir[3];
			bit              off_face;
			neighbor_t       res;
			side = side_eff();
			off_face = 1'b0;
			// Derive the step per axis; bit 3 turns a clear bit into a decrement
			for (int k = 0; k < 3; k++) begin
				if (code[k] == code[lnaddr_pkg::DOWN_BIT]) dir[k] = STEP_NONE;
				else if (code[k]) dir[k] = STEP_INC;
				else dir[k] = STEP_DEC;
			end
			coord[0] = site % side;
			coord[1] = (site / side) % side;
			coord[2] = site / (side * side);
			for (int k = 0; k < 3; k++) begin
				if (!bounded) begin
					moved[k] = coord[k] % side;
					if (dir[k] == STEP_INC) moved[k] = (moved[k] + 1) % side;
					else if (dir[k] == STEP_DEC) moved[k] = (moved[k] + side - 1) % side;
				end else begin
					moved[k] = coord[k];
					if (dir[k] == STEP_INC) moved[k] = coord[k] + 1;
					else if (dir[k] == STEP_DEC) begin
						if (coord[k] == 0) off_face = 1'b1;
						else moved[k] = coord[k] - 1;
					end
					if (moved[k] >= side) off_face = 1'b1;
				end
			end
			res.oob = off_face;
			res.addr = '0;
			if (!off_face) begin
				sum = moved[0] + moved[1] * side + moved[2] * side * side;
				res.addr = sum[lnaddr_pkg::IDX_W-1:0];
			end
			return res;
		endfunction

		function void note_request(logic [lnaddr_pkg::IDX_W-1:0] site,
				logic [lnaddr_pkg::UNIT_W-1:0] code);
			expected_neighbors.push_back(neighbor_of(site, code));
		endfunction

		function int pending();
			return expected_neighbors.size();
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			error_count++;
		endtask

		task check_result(logic [lnaddr_pkg::M_TDATA_W-1:0] data, logic user);
			neighbor_t want;
			if (expected_neighbors.size() == 0) begin
				report_mismatch($sformatf("result %h/%b with no request pending", data, user));
				return;
			end
			want = expected_neighbors.pop_front();
			if (data[lnaddr_pkg::IDX_W-1:0] != want.addr)
				report_mismatch($sformatf("neighbor_index %h, expected %h",
					data[lnaddr_pkg::IDX_W-1:0], want.addr));
			if (user != want.oob)
				report_mismatch($sformatf("out_of_bounds %b, expected %b", user, want.oob));
		endtask
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_wr_en = 1'b0;
	lnaddr_pkg::cfg_reg_t                cfg_index = lnaddr_pkg::CFG_LATTICE_SIDE;
	logic [lnaddr_pkg::SIDE_W-1:0]       cfg_data = '0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [lnaddr_pkg::S_TDATA_W-1:0]    s_tdata = '0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [lnaddr_pkg::M_TDATA_W-1:0]    m_tdata;
	logic                                m_tuser;

	neighbor_checker board = new();
	bit idle_on = 1'b1;
	bit burst = 1'b0;
	bit hold_request = 1'b0;

	lattice_neighbor_address dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 60);
	endfunction

	// Favor lattice faces so steps cross them often
	function automatic int unsigned pick_coord(int unsigned side);
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return 0;
		if (r < 4) return side - 1;
		return $urandom_range(0, side - 1);
	endfunction

	function automatic logic [lnaddr_pkg::IDX_W-1:0] random_site(int unsigned side);
		int unsigned t, u, v;
		if ($urandom_range(0, 9) == 0) return lnaddr_pkg::IDX_W'($urandom());
		t = pick_coord(side);
		u = pick_coord(side);
		v = pick_coord(side);
		return lnaddr_pkg::IDX_W'(t + u * side + v * side * side);
	endfunction

	function automatic logic [lnaddr_pkg::UNIT_W-1:0] random_code();
		return lnaddr_pkg::UNIT_W'($urandom_range(0, 15));
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic send_request(input logic [lnaddr_pkg::IDX_W-1:0] site,
		input logic [lnaddr_pkg::UNIT_W-1:0] code);
		int gap;
		gap = 0;
		if (idle_on && !burst && $urandom_range(0, 99) < 40) gap = pick_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(lnaddr_pkg::S_TDATA_W-lnaddr_pkg::IDX_W-lnaddr_pkg::UNIT_W){1'b0}},
			code, site};
		do @(posedge clk); while (!s_tready);
		board.note_request(site, code);
	endtask

	// Wait for the pipeline to empty, then write both registers
	task automatic write_config(input logic [lnaddr_pkg::SIDE_W-1:0] side, input bit mode);
		while (board.pending() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= lnaddr_pkg::CFG_LATTICE_SIDE;
		cfg_data <= side;
		@(posedge clk);
		cfg_index <= lnaddr_pkg::CFG_WRAP_MODE;
		cfg_data <= {{(lnaddr_pkg::SIDE_W-1){1'b0}}, mode};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_config(side, mode);
	endtask

	task automatic run_phase(input logic [lnaddr_pkg::SIDE_W-1:0] side, input bit mode,
		input int count, input bit idle, input bit press);
		write_config(side, mode);
		idle_on = idle;
		burst = press;
		if (press) hold_request = 1'b1;
		repeat (count) send_request(random_site(board.side_eff()), random_code());
		s_tvalid <= 1'b0;
		burst = 1'b0;
	endtask

	// Drain results with random back-pressure
	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if (idle_on && $urandom_range(0, 99) < 20) begin
				m_tready <= 1'b0;
				stall = pick_len() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Abort when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int                             side_pick;
		logic [lnaddr_pkg::UNIT_W-1:0]  code;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every code from the origin, then far corners and overflowing sites
		idle_on = 1'b0;
		for (int c = 0; c < 16; c++) begin
			code = lnaddr_pkg::UNIT_W'(c);
			send_request(24'd0, code);
		end
		send_request(24'hFFFFFF, 4'd7);
		send_request(24'hFFFFFF, 4'd8);
		send_request(24'd32767, 4'd7);
		send_request(24'd32767, 4'd8);
		send_request(24'd1057, 4'd15);
		idle_on = 1'b1;
		repeat (200) send_request(random_site(board.side_eff()), random_code());
		s_tvalid <= 1'b0;

		run_phase(9'd32, 1'b1, 200, 1'b1, 1'b0);
		run_phase(9'd1, 1'b0, 100, 1'b1, 1'b0);
		run_phase(9'd1, 1'b1, 100, 1'b0, 1'b0);
		run_phase(9'd0, 1'b1, 80, 1'b1, 1'b0);
		run_phase(9'd2, 1'b1, 150, 1'b1, 1'b0);
		run_phase(9'd3, 1'b0, 150, 1'b1, 1'b0);
		run_phase(9'd256, 1'b0, 200, 1'b1, 1'b1);
		run_phase(9'd256, 1'b1, 200, 1'b1, 1'b0);
		run_phase(9'd511, 1'b1, 120, 1'b0, 1'b0);
		run_phase(9'd300, 1'b0, 100, 1'b1, 1'b0);
		repeat (3) begin
			side_pick = $urandom_range(1, 256);
			run_phase(side_pick[lnaddr_pkg::SIDE_W-1:0], 1'($urandom_range(0, 1)), 100,
				1'b1, 1'b0);
		end

		// Let the last results out
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending() != 0) board.report_mismatch("requests left without a result");
		if (board.error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
